// ===== src/c_subset_tokenizer_core_assert.svh =====
// Assertion helpers for the tokenizer core.
`ifndef C_SUBSET_TOKENIZER_CORE_ASSERT_SVH
`define C_SUBSET_TOKENIZER_CORE_ASSERT_SVH

// Condition that holds at every edge outside reset.
`define CST_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequence in the same cycle.
`define CST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the next cycle.
`define CST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cst_pkg.sv =====
package cst_pkg;

  typedef logic [23:0] offset_t;
  typedef logic [15:0] pos_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_final;
  } src_item_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [2:0] keyword_index;
    offset_t    start_offset;
    pos_t       start_row;
    pos_t       start_col;
    pos_t       tok_length;
    logic       last_token;
  } tok_item_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } kw_hit_t;

  // Token kinds
  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_INVALID = 5'd1;
  localparam logic [4:0] KIND_KEYWORD = 5'd2;
  localparam logic [4:0] KIND_IDENT   = 5'd3;
  localparam logic [4:0] KIND_NUMBER  = 5'd4;
  localparam logic [4:0] KIND_LPAREN  = 5'd5;
  localparam logic [4:0] KIND_RPAREN  = 5'd6;
  localparam logic [4:0] KIND_LBRACE  = 5'd7;
  localparam logic [4:0] KIND_RBRACE  = 5'd8;
  localparam logic [4:0] KIND_SEMI    = 5'd9;
  localparam logic [4:0] KIND_COMMA   = 5'd10;
  localparam logic [4:0] KIND_PLUS    = 5'd11;
  localparam logic [4:0] KIND_INC     = 5'd12;
  localparam logic [4:0] KIND_MINUS   = 5'd13;
  localparam logic [4:0] KIND_DEC     = 5'd14;
  localparam logic [4:0] KIND_STAR    = 5'd15;
  localparam logic [4:0] KIND_SLASH   = 5'd16;
  localparam logic [4:0] KIND_PERCENT = 5'd17;
  localparam logic [4:0] KIND_ASSIGN  = 5'd18;
  localparam logic [4:0] KIND_EQ      = 5'd19;
  localparam logic [4:0] KIND_NOT     = 5'd20;
  localparam logic [4:0] KIND_NE      = 5'd21;
  localparam logic [4:0] KIND_LT      = 5'd22;
  localparam logic [4:0] KIND_GT      = 5'd23;
  localparam logic [4:0] KIND_LE      = 5'd24;
  localparam logic [4:0] KIND_GE      = 5'd25;
  localparam logic [4:0] KIND_ANDAND  = 5'd26;
  localparam logic [4:0] KIND_OROR    = 5'd27;
  localparam logic [4:0] KIND_LONE    = 5'd28;
  // no match from the pair table
  localparam logic [4:0] KIND_NONE    = 5'd0;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  // Keywords, first byte in the low bits, zero padded: if else while return int void
  localparam int unsigned KW_COUNT = 6;
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h0000_0000_6669, 48'h0000_6573_6C65, 48'h0065_6C69_6877,
    48'h6E72_7574_6572, 48'h0000_0074_6E69, 48'h0000_6469_6F76
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd5, 3'd6, 3'd3, 3'd4};

  // Result queue sizing
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned MAX_RES = 3;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // len is the word length, 7 standing for anything longer than six
  function automatic kw_hit_t kw_lookup(logic [47:0] w, logic [2:0] len);
    kw_hit_t r;
    r = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (w == KW_TEXT[i] && len == KW_LEN[i]) begin
        r.hit = 1'b1;
        r.idx = 3'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] lone_kind(logic [7:0] h);
    logic [4:0] k;
    unique case (h)
      CH_SLASH:       k = KIND_SLASH;
      "!":            k = KIND_NOT;
      CH_EQ:          k = KIND_ASSIGN;
      "<":            k = KIND_LT;
      ">":            k = KIND_GT;
      "+":            k = KIND_PLUS;
      "-":            k = KIND_MINUS;
      CH_AMP, CH_BAR: k = KIND_LONE;
      default:        k = KIND_INVALID;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] pair_kind(logic [7:0] h, logic [7:0] c);
    logic [4:0] k;
    k = KIND_NONE;
    if (c == CH_EQ) begin
      unique case (h)
        "!":     k = KIND_NE;
        CH_EQ:   k = KIND_EQ;
        "<":     k = KIND_LE;
        ">":     k = KIND_GE;
        default: k = KIND_NONE;
      endcase
    end else if (h == c) begin
      unique case (h)
        "+":     k = KIND_INC;
        "-":     k = KIND_DEC;
        CH_AMP:  k = KIND_ANDAND;
        CH_BAR:  k = KIND_OROR;
        default: k = KIND_NONE;
      endcase
    end
    return k;
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      "*":     k = KIND_STAR;
      "%":     k = KIND_PERCENT;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

endpackage

// ===== src/c_subset_tokenizer_core.sv =====
// Streaming tokenizer for a small C subset. Source bytes enter one per transfer on the
// src channel and tokens leave one per transfer on the tok channel. Each byte is
// scanned in the cycle it is accepted; it yields zero to three tokens, which go into a
// four-entry result queue, so a byte is taken every cycle as long as the queue holds at
// most one waiting token. Bytes that each yield at most one token stream at one per
// cycle while tok_stall stays low; the tokens of a byte that yields two or three
// leave one per transfer. A byte flagged is_final flushes the pending token, then
// sends an end token with last_token set, carrying the position just past the text,
// and the block starts a fresh text with the next byte. Offsets saturate at
// 2^OFFSET_BITS-1; rows, columns and lengths saturate at 2^POS_BITS-1.
`include "c_subset_tokenizer_core_assert.svh"

module c_subset_tokenizer_core #(
  parameter int unsigned OFFSET_BITS = 24,
  parameter int unsigned POS_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_stall,
  input  cst_pkg::src_item_t    src_item,
  output logic                  tok_valid,
  input  logic                  tok_stall,
  output cst_pkg::tok_item_t    tok_item
);

  typedef enum logic [2:0] {M_IDLE, M_WORD, M_NUMBER, M_SYMBOL, M_COMMENT} mode_t;

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [POS_BITS-1:0]    posn_t;

  localparam posn_t POS_ONE = posn_t'(1);

  mode_t      mode, mode_next;
  logic [7:0] held, held_next;
  logic [47:0] word, word_next;
  off_t       cur_off, cur_off_next, tk_off, tk_off_next;
  posn_t      cur_row, cur_row_next, cur_col, cur_col_next;
  posn_t      tk_row, tk_row_next, tk_col, tk_col_next, tk_len, tk_len_next;

  cst_pkg::tok_item_t res [cst_pkg::QDEPTH];
  logic [1:0] res_n;

  cst_pkg::tok_item_t q [cst_pkg::QDEPTH];
  cst_pkg::tok_item_t q_next [cst_pkg::QDEPTH];
  logic [2:0] count, count_next;

  logic acc, pop;

  function automatic off_t sat_off(off_t v);
    return (v == '1) ? v : v + off_t'(1);
  endfunction

  function automatic posn_t sat_pos(posn_t v);
    return (v == '1) ? v : v + POS_ONE;
  endfunction

  function automatic cst_pkg::tok_item_t make_tok(logic [4:0] kind, logic [2:0] kw,
                                                  off_t off, posn_t row, posn_t col,
                                                  posn_t len, logic last);
    cst_pkg::tok_item_t t;
    t.kind          = kind;
    t.keyword_index = kw;
    t.start_offset  = cst_pkg::offset_t'(off);
    t.start_row     = cst_pkg::pos_t'(row);
    t.start_col     = cst_pkg::pos_t'(col);
    t.tok_length    = cst_pkg::pos_t'(len);
    t.last_token    = last;
    return t;
  endfunction

  function automatic cst_pkg::tok_item_t word_tok(logic [47:0] w, off_t off, posn_t row,
                                                  posn_t col, posn_t len);
    cst_pkg::kw_hit_t kh;
    logic [2:0] lc;
    lc = (len <= posn_t'(6)) ? 3'(len) : 3'd7;
    kh = cst_pkg::kw_lookup(w, lc);
    if (kh.hit) begin
      return make_tok(cst_pkg::KIND_KEYWORD, kh.idx, off, row, col, len, 1'b0);
    end
    return make_tok(cst_pkg::KIND_IDENT, 3'd0, off, row, col, len, 1'b0);
  endfunction

  assign acc       = src_valid && !src_stall;
  assign pop       = tok_valid && !tok_stall;
  assign src_stall = count > 3'(cst_pkg::QDEPTH - cst_pkg::MAX_RES);
  assign tok_valid = count != 3'd0;
  assign tok_item  = q[0];

  // Scan one byte
  always_comb begin
    logic [7:0] c;
    logic       used;
    logic [4:0] pk;
    c           = src_item.char_byte;
    used        = 1'b0;
    pk          = cst_pkg::pair_kind(held, c);
    mode_next   = mode;
    held_next   = held;
    word_next   = word;
    cur_off_next = cur_off;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    tk_off_next = tk_off;
    tk_row_next = tk_row;
    tk_col_next = tk_col;
    tk_len_next = tk_len;
    res_n       = 2'd0;
    for (int i = 0; i < cst_pkg::QDEPTH; i++) begin
      res[i] = '0;
    end

    unique case (mode)
      M_WORD: begin
        if (cst_pkg::is_alpha(c) || cst_pkg::is_digit(c)) begin
          if (tk_len < posn_t'(6)) begin
            word_next[{tk_len[2:0], 3'b000} +: 8] = c;
          end
          tk_len_next = sat_pos(tk_len);
          used = 1'b1;
        end else begin
          res[res_n] = word_tok(word, tk_off, tk_row, tk_col, tk_len);
          res_n = res_n + 2'd1;
          mode_next = M_IDLE;
        end
      end
      M_NUMBER: begin
        if (cst_pkg::is_digit(c)) begin
          tk_len_next = sat_pos(tk_len);
          used = 1'b1;
        end else begin
          res[res_n] = make_tok(cst_pkg::KIND_NUMBER, 3'd0, tk_off, tk_row, tk_col,
                                tk_len, 1'b0);
          res_n = res_n + 2'd1;
          mode_next = M_IDLE;
        end
      end
      M_SYMBOL: begin
        if (held == cst_pkg::CH_SLASH && c == cst_pkg::CH_SLASH) begin
          mode_next = M_COMMENT;
          used = 1'b1;
        end else if (pk != cst_pkg::KIND_NONE) begin
          tk_len_next = posn_t'(2);
          res[res_n] = make_tok(pk, 3'd0, tk_off, tk_row, tk_col, posn_t'(2), 1'b0);
          res_n = res_n + 2'd1;
          mode_next = M_IDLE;
          used = 1'b1;
        end else begin
          res[res_n] = make_tok(cst_pkg::lone_kind(held), 3'd0, tk_off, tk_row, tk_col,
                                tk_len, 1'b0);
          res_n = res_n + 2'd1;
          mode_next = M_IDLE;
        end
      end
      M_COMMENT: begin
        if (c == cst_pkg::CH_NL) begin
          mode_next = M_IDLE;
        end
        used = 1'b1;
      end
      default: mode_next = M_IDLE;
    endcase

    if (!used && !cst_pkg::is_space(c)) begin
      tk_off_next = cur_off;
      tk_row_next = cur_row;
      tk_col_next = cur_col;
      tk_len_next = POS_ONE;
      if (cst_pkg::is_alpha(c)) begin
        word_next = {40'd0, c};
        mode_next = M_WORD;
      end else if (cst_pkg::is_digit(c)) begin
        mode_next = M_NUMBER;
      end else if (cst_pkg::lone_kind(c) != cst_pkg::KIND_INVALID) begin
        held_next = c;
        mode_next = M_SYMBOL;
      end else begin
        res[res_n] = make_tok(cst_pkg::single_kind(c), 3'd0, cur_off, cur_row, cur_col,
                              POS_ONE, 1'b0);
        res_n = res_n + 2'd1;
      end
    end

    // every byte advances the position exactly once
    cur_off_next = sat_off(cur_off);
    if (c == cst_pkg::CH_NL) begin
      cur_row_next = sat_pos(cur_row);
      cur_col_next = POS_ONE;
    end else begin
      cur_col_next = sat_pos(cur_col);
    end

    if (src_item.is_final) begin
      unique case (mode_next)
        M_WORD: begin
          res[res_n] = word_tok(word_next, tk_off_next, tk_row_next, tk_col_next,
                                tk_len_next);
          res_n = res_n + 2'd1;
        end
        M_NUMBER: begin
          res[res_n] = make_tok(cst_pkg::KIND_NUMBER, 3'd0, tk_off_next, tk_row_next,
                                tk_col_next, tk_len_next, 1'b0);
          res_n = res_n + 2'd1;
        end
        M_SYMBOL: begin
          res[res_n] = make_tok(cst_pkg::lone_kind(held_next), 3'd0, tk_off_next,
                                tk_row_next, tk_col_next, tk_len_next, 1'b0);
          res_n = res_n + 2'd1;
        end
        default: ;
      endcase
      res[res_n] = make_tok(cst_pkg::KIND_END, 3'd0, cur_off_next, cur_row_next,
                            cur_col_next, '0, 1'b1);
      res_n = res_n + 2'd1;
      // start a fresh text
      mode_next    = M_IDLE;
      held_next    = '0;
      word_next    = '0;
      cur_off_next = '0;
      cur_row_next = POS_ONE;
      cur_col_next = POS_ONE;
      tk_off_next  = '0;
      tk_row_next  = POS_ONE;
      tk_col_next  = POS_ONE;
      tk_len_next  = '0;
    end
  end

  // Result queue: head at entry 0, shift on pop, append new results behind
  always_comb begin
    logic [2:0] base;
    logic [2:0] push_n;
    logic [1:0] k;
    base   = count - {2'd0, pop};
    push_n = acc ? {1'b0, res_n} : 3'd0;
    count_next = base + push_n;
    for (int i = 0; i < cst_pkg::QDEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < cst_pkg::QDEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
    end
    for (int i = 0; i < cst_pkg::QDEPTH; i++) begin
      k = 2'(3'(i) - base);
      if (3'(i) >= base && {1'b0, k} < push_n) begin
        q_next[i] = res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      held    <= '0;
      word    <= '0;
      cur_off <= '0;
      cur_row <= POS_ONE;
      cur_col <= POS_ONE;
      tk_off  <= '0;
      tk_row  <= POS_ONE;
      tk_col  <= POS_ONE;
      tk_len  <= '0;
      count   <= '0;
    end else begin
      if (acc) begin
        mode    <= mode_next;
        held    <= held_next;
        word    <= word_next;
        cur_off <= cur_off_next;
        cur_row <= cur_row_next;
        cur_col <= cur_col_next;
        tk_off  <= tk_off_next;
        tk_row  <= tk_row_next;
        tk_col  <= tk_col_next;
        tk_len  <= tk_len_next;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < cst_pkg::QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  `CST_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= 3'(cst_pkg::QDEPTH), "result queue overflow")
  `CST_ASSERT_NEXT(a_final_resets, clk, rst, acc && src_item.is_final, mode == M_IDLE && cur_off == '0 && cur_row == POS_ONE && tk_len == '0, "state not cleared after end of text")
  `CST_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !acc, count == $past(count) - 3'd1, "queue count wrong on drain")
  `CST_ASSERT_IMP(a_last_is_end, clk, rst, tok_valid && tok_item.last_token, tok_item.kind == cst_pkg::KIND_END && tok_item.tok_length == '0, "last flag on a non-end token")
  `CST_ASSERT_IMP(a_held_symbol, clk, rst, mode == M_SYMBOL, cst_pkg::lone_kind(held) != cst_pkg::KIND_INVALID, "symbol mode holds a byte that starts no symbol")

endmodule
